### design/cilp_pkg.sv
`default_nettype none
package cilp_pkg;

  // radix of the token being parsed
  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_HEX = 2'd2
  } radix_t;

  // u / l / ll suffix recogniser phases
  typedef enum logic [3:0] {
    SP_START = 4'd0,
    SP_U     = 4'd1,
    SP_UL    = 4'd2,
    SP_ULL   = 4'd3,
    SP_L     = 4'd4,
    SP_LL    = 4'd5,
    SP_LU    = 4'd6,
    SP_LLU   = 4'd7,
    SP_BAD   = 4'd8
  } sfx_phase_t;

  // suffix codes
  localparam logic [2:0] SFX_NONE = 3'd0;
  localparam logic [2:0] SFX_U    = 3'd1;
  localparam logic [2:0] SFX_L    = 3'd2;
  localparam logic [2:0] SFX_UL   = 3'd3;
  localparam logic [2:0] SFX_LL   = 3'd4;
  localparam logic [2:0] SFX_ULL  = 3'd5;
  localparam logic [2:0] SFX_BAD  = 3'd6;

  // type codes
  localparam logic [2:0] TY_INT    = 3'd0;
  localparam logic [2:0] TY_UINT   = 3'd1;
  localparam logic [2:0] TY_LONG   = 3'd2;
  localparam logic [2:0] TY_ULONG  = 3'd3;
  localparam logic [2:0] TY_LLONG  = 3'd4;
  localparam logic [2:0] TY_ULLONG = 3'd5;
  localparam logic [2:0] TY_NONE   = 3'd6;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_OCT  = 2'd1;
  localparam logic [1:0] ST_BAD_SFX  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  localparam int unsigned ValueW = 64;
  localparam int unsigned OutDataW = 80;

  // per-token parse state
  typedef struct packed {
    logic [1:0]        char_index;
    radix_t            radix;
    logic [ValueW-1:0] acc;
    logic              ovf;
    logic              oct_err;
    logic              in_sfx;
    sfx_phase_t        phase;
    logic              ell_upper;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    char_index: 2'd0, radix: RADIX_DEC, acc: '0, ovf: 1'b0, oct_err: 1'b0,
    in_sfx: 1'b0, phase: SP_START, ell_upper: 1'b0
  };

  // one result word
  typedef struct packed {
    logic              forced_unsigned;
    logic [1:0]        status;
    logic [2:0]        suffix_code;
    logic [2:0]        type_code;
    logic [ValueW-1:0] literal_value;
  } parse_result_t;

endpackage
`default_nettype wire

### design/cilp_step.sv
`default_nettype none
module cilp_step (
  input  wire cilp_pkg::parse_state_t  st,
  input  wire logic [7:0]              char_code,
  input  wire logic                    last_char,
  input  wire logic                    long_is_64,
  output cilp_pkg::parse_state_t       st_nxt,
  output cilp_pkg::parse_result_t      res
);
  import cilp_pkg::*;

  parse_state_t      s;
  radix_t            radix_w;
  logic              skip;
  logic [3:0]        dig;
  logic              is_num, is_lc, is_uc, dig_ok;
  logic              is_u, is_l, same_l;
  logic              ovf_mul;
  logic [ValueW-1:0] prod;
  logic [ValueW:0]   sum;
  logic [2:0]        sfx;
  logic [1:0]        stat;
  logic [2:0]        ty;
  logic [ValueW-1:0] v;
  logic              dec;
  logic              le_int, le_uint, le_llong, le_lmax, le_ulmax;

  // digit decode
  always_comb begin
    is_num = (char_code >= 8'h30) && (char_code <= 8'h39);
    is_lc  = (char_code >= 8'h61) && (char_code <= 8'h66);
    is_uc  = (char_code >= 8'h41) && (char_code <= 8'h46);
    if (is_num) begin
      dig = char_code[3:0];
    end else if (is_lc || is_uc) begin
      dig = 4'(char_code[2:0] + 3'd1) + 4'd8;   // 'a'/'A' -> 10
    end else begin
      dig = 4'd0;
    end
    is_u   = (char_code == 8'h75) || (char_code == 8'h55);
    is_l   = (char_code == 8'h6C) || (char_code == 8'h4C);
    same_l = is_l && ((char_code == 8'h4C) == st.ell_upper);
  end

  always_comb begin
    s       = st;
    radix_w = st.radix;
    skip    = 1'b0;
    dig_ok  = 1'b0;
    ovf_mul = 1'b0;
    prod    = '0;
    sum     = '0;
    if (st.char_index != 2'd2) begin
      s.char_index = st.char_index + 2'd1;
    end
    if (!st.oct_err) begin
      if ((st.char_index == 2'd0) && (char_code == 8'h30)) begin
        s.radix = RADIX_OCT;
        skip    = 1'b1;
      end else if ((st.char_index == 2'd1) && (st.radix == RADIX_OCT) &&
                   ((char_code == 8'h78) || (char_code == 8'h58))) begin
        // a lone 0x is decimal zero and its x opens the suffix
        if (last_char) begin
          radix_w = RADIX_DEC;
        end else begin
          radix_w = RADIX_HEX;
          skip    = 1'b1;
        end
      end
      s.radix = (st.char_index == 2'd0 && char_code == 8'h30) ? RADIX_OCT : radix_w;
      unique case (radix_w)
        RADIX_HEX: dig_ok = is_num || is_lc || is_uc;
        RADIX_OCT: dig_ok = is_num && (dig < 4'd8);
        default:   dig_ok = is_num;
      endcase
      unique case (radix_w)
        RADIX_HEX: begin
          ovf_mul = |st.acc[ValueW-1:ValueW-4];
          prod    = st.acc << 4;
        end
        RADIX_OCT: begin
          ovf_mul = |st.acc[ValueW-1:ValueW-3];
          prod    = st.acc << 3;
        end
        default: begin
          ovf_mul = st.acc > 64'h1999_9999_9999_9999;
          prod    = (st.acc << 3) + (st.acc << 1);
        end
      endcase
      sum = {1'b0, prod} + {{(ValueW-3){1'b0}}, dig};
      if (!skip) begin
        if (!st.in_sfx && dig_ok) begin
          s.acc = sum[ValueW-1:0];
          s.ovf = st.ovf | ovf_mul | sum[ValueW];
        end else if (!st.in_sfx && (radix_w == RADIX_OCT) && is_num) begin
          s.oct_err = 1'b1;                    // 8 or 9 in an octal number
        end else begin
          s.in_sfx = 1'b1;
          unique case (st.in_sfx ? st.phase : SP_START)
            SP_START: begin
              if (is_u) begin
                s.phase = SP_U;
              end else if (is_l) begin
                s.phase     = SP_L;
                s.ell_upper = char_code == 8'h4C;
              end else begin
                s.phase = SP_BAD;
              end
            end
            SP_U: begin
              if (is_l) begin
                s.phase     = SP_UL;
                s.ell_upper = char_code == 8'h4C;
              end else begin
                s.phase = SP_BAD;
              end
            end
            SP_UL:   s.phase = same_l ? SP_ULL : SP_BAD;
            SP_L:    s.phase = same_l ? SP_LL : (is_u ? SP_LU : SP_BAD);
            SP_LL:   s.phase = is_u ? SP_LLU : SP_BAD;
            default: s.phase = SP_BAD;
          endcase
        end
      end
    end
  end

  // result from the updated state
  always_comb begin
    if (!s.in_sfx) begin
      sfx = SFX_NONE;
    end else begin
      unique case (s.phase) inside
        SP_U:           sfx = SFX_U;
        SP_UL, SP_LU:   sfx = SFX_UL;
        SP_ULL, SP_LLU: sfx = SFX_ULL;
        SP_L:           sfx = SFX_L;
        SP_LL:          sfx = SFX_LL;
        default:        sfx = SFX_BAD;
      endcase
    end
    if (s.oct_err) begin
      stat = ST_BAD_OCT;
    end else if (sfx == SFX_BAD) begin
      stat = ST_BAD_SFX;
    end else if (s.ovf) begin
      stat = ST_OVERFLOW;
    end else begin
      stat = ST_OK;
    end

    v        = s.acc;
    dec      = s.radix == RADIX_DEC;
    le_int   = v[ValueW-1:31] == '0;
    le_uint  = v[ValueW-1:32] == '0;
    le_llong = !v[ValueW-1];
    le_lmax  = long_is_64 ? le_llong : le_int;
    le_ulmax = long_is_64 | le_uint;

    case (sfx)
      SFX_ULL: ty = TY_ULLONG;
      SFX_LL:  ty = le_llong ? TY_LLONG : (dec ? TY_NONE : TY_ULLONG);
      SFX_UL:  ty = le_ulmax ? TY_ULONG : TY_ULLONG;
      SFX_L: begin
        if (le_lmax)               ty = TY_LONG;
        else if (!dec && le_ulmax) ty = TY_ULONG;
        else if (le_llong)         ty = TY_LLONG;
        else                       ty = dec ? TY_NONE : TY_ULLONG;
      end
      SFX_U: begin
        if (le_uint)       ty = TY_UINT;
        else if (le_ulmax) ty = TY_ULONG;
        else               ty = TY_ULLONG;
      end
      default: begin
        if (le_int)                ty = TY_INT;
        else if (!dec && le_uint)  ty = TY_UINT;
        else if (le_lmax)          ty = TY_LONG;
        else if (!dec && le_ulmax) ty = TY_ULONG;
        else if (le_llong)         ty = TY_LLONG;
        else                       ty = dec ? TY_NONE : TY_ULLONG;
      end
    endcase

    res.status = stat;
    if (stat == ST_OK) begin
      res.literal_value   = v;
      res.type_code       = (ty == TY_NONE) ? TY_ULLONG : ty;
      res.suffix_code     = sfx;
      res.forced_unsigned = ty == TY_NONE;
    end else begin
      res.literal_value   = '0;
      res.type_code       = TY_INT;
      res.suffix_code     = SFX_NONE;
      res.forced_unsigned = 1'b0;
    end

    st_nxt = last_char ? PARSE_RESET : s;
  end

endmodule
`default_nettype wire

### design/c_integer_literal_parser_unit.sv
`default_nettype none
// C integer constant parser.
// Input stream: one character of an integer token per word on in_tdata,
// in_tlast high on the token's final character. Output stream: one result
// word per token (value, C type, suffix code, status, forced-unsigned flag),
// issued for the word that carries in_tlast; other words give no output.
// cfg_wr_en/cfg_wr_data write long_is_64 (1: LP64 long, 0: 32-bit long);
// write it only while no token is in flight.
// Timing: a character is parsed in the cycle it is accepted; the result
// word is registered into the result register or, while that is held,
// the skid entry. Throughput: one character per cycle while in_tready is
// high; the shift-and-add and 64-bit range compares are combinational.
// Reset (rst_n low, synchronous) clears the parse state, empties the
// output and sets long_is_64 to 1.
// Stall: a two-deep output (result register plus skid entry) holds results
// while out_tready is low; in_tready drops only once the skid entry is full.
module c_integer_literal_parser_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_code
  input  wire logic        in_tlast,   // last_char
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [cilp_pkg::OutDataW-1:0] out_tdata,
  // [63:0] literal_value, [66:64] type_code, [69:67] suffix_code,
  // [71:70] status, [72] forced_unsigned, [79:73] zero
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data  // long_is_64
);
  import cilp_pkg::*;

  parse_state_t  st_r, st_nxt;
  parse_result_t res;
  parse_result_t out_data_r, skid_data_r;
  logic          out_valid_r, skid_valid_r;
  logic          long_is_64_r;
  logic          take, push, pop;

  cilp_step u_step (
    .st         (st_r),
    .char_code  (in_tdata),
    .last_char  (in_tlast),
    .long_is_64 (long_is_64_r),
    .st_nxt     (st_nxt),
    .res        (res)
  );

  assign in_tready  = !skid_valid_r;
  assign take       = in_tvalid && in_tready;
  assign push       = take && in_tlast;
  assign pop        = out_valid_r && out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OutDataW - $bits(parse_result_t)){1'b0}}, out_data_r};

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= PARSE_RESET;
      long_is_64_r <= 1'b1;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        long_is_64_r <= cfg_wr_data;
      end
      if (take) begin
        st_r <= st_nxt;
      end
      if (!out_valid_r || pop) begin
        out_valid_r  <= skid_valid_r || push;
        skid_valid_r <= 1'b0;
      end else if (push) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (push) begin
        out_data_r <= res;
      end
    end else if (push) begin
      skid_data_r <= res;
    end
  end

endmodule
`default_nettype wire

### bench/tb_c_integer_literal_parser_unit.sv
`timescale 1ns / 1ps
module tb_c_integer_literal_parser_unit;
  import cilp_pkg::*;

  // Generous ceiling: the slowest legal run (every character after the
  // longest random gap, every result after the longest random stall, plus
  // the long hold-off) stays well under a tenth of this.
  localparam int CYCLE_LIMIT = 500000;
  localparam int SHOWN_MISMATCHES = 10;

  localparam logic [63:0] INT_MAX_V   = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] UINT_MAX_V  = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] LLONG_MAX_V = 64'h7FFF_FFFF_FFFF_FFFF;

  // shapes of the generated suffix
  typedef enum int {
    SG_NONE, SG_U, SG_L, SG_UL, SG_LU, SG_ULL, SG_LLU, SG_LL, SG_MIXED_LL, SG_JUNK
  } suffix_shape_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = 8'd0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;

  always #1 clk = ~clk;

  c_integer_literal_parser_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // ---------------------------------------------------------------------------
  // Lexer shadow: its own parse state and long width, advanced once per
  // accepted word. A word with tlast set yields one predicted result.
  // ---------------------------------------------------------------------------
  parse_state_t  lex = PARSE_RESET;
  logic          long_is_64_shadow = 1'b1;
  parse_result_t pending_results[$];

  byte unsigned token_buf[$];
  bit  tx_burst = 1'b0;   // sender offers back to back
  bit  rx_burst = 1'b0;   // receiver always ready
  int  stall_hold = 0;    // long receiver hold-off, in cycles

  int cycle_count = 0;
  int tokens_sent = 0;
  int chars_sent = 0;
  int results_checked = 0;
  int mismatch_count = 0;
  parse_result_t got_word, want_word;

  function automatic int digit_in_radix(byte unsigned c, radix_t r);
    int d;
    d = -1;
    if (c >= "0" && c <= "9") d = c - "0";
    else if (c >= "a" && c <= "f") d = c - "a" + 10;
    else if (c >= "A" && c <= "F") d = c - "A" + 10;
    if (r == RADIX_OCT && d > 7) d = -1;
    if (r == RADIX_DEC && d > 9) d = -1;
    return d;
  endfunction

  // u/l/ll recogniser; both letters of ll must share a case
  task automatic advance_suffix(input byte unsigned c);
    logic is_u, is_l, same_l;
    is_u = (c == "u" || c == "U");
    is_l = (c == "l" || c == "L");
    same_l = is_l && ((c == "L") == lex.ell_upper);
    case (lex.phase)
      SP_START: begin
        if (is_u) lex.phase = SP_U;
        else if (is_l) begin
          lex.phase = SP_L;
          lex.ell_upper = (c == "L");
        end else lex.phase = SP_BAD;
      end
      SP_U: begin
        if (is_l) begin
          lex.phase = SP_UL;
          lex.ell_upper = (c == "L");
        end else lex.phase = SP_BAD;
      end
      SP_UL: lex.phase = same_l ? SP_ULL : SP_BAD;
      SP_L: begin
        if (same_l) lex.phase = SP_LL;
        else lex.phase = is_u ? SP_LU : SP_BAD;
      end
      SP_LL: lex.phase = is_u ? SP_LLU : SP_BAD;
      default: lex.phase = SP_BAD;
    endcase
  endtask

  function automatic logic [2:0] suffix_code_of(parse_state_t s);
    if (!s.in_sfx) return SFX_NONE;
    case (s.phase) inside
      SP_U:           return SFX_U;
      SP_UL, SP_LU:   return SFX_UL;
      SP_ULL, SP_LLU: return SFX_ULL;
      SP_L:           return SFX_L;
      SP_LL:          return SFX_LL;
      default:        return SFX_BAD;
    endcase
  endfunction

  // C99 type ladder; TY_NONE when a decimal value fits nothing signed
  function automatic logic [2:0] c_type_for(logic [63:0] v, logic dec, logic [2:0] sfx,
                                            logic lp64);
    logic [63:0] lmax, ulmax;
    lmax  = lp64 ? LLONG_MAX_V : INT_MAX_V;
    ulmax = lp64 ? 64'hFFFF_FFFF_FFFF_FFFF : UINT_MAX_V;
    case (sfx)
      SFX_ULL: return TY_ULLONG;
      SFX_LL: begin
        if (v <= LLONG_MAX_V) return TY_LLONG;
        return dec ? TY_NONE : TY_ULLONG;
      end
      SFX_UL: return (v <= ulmax) ? TY_ULONG : TY_ULLONG;
      SFX_L: begin
        if (v <= lmax) return TY_LONG;
        if (!dec && v <= ulmax) return TY_ULONG;
        if (v <= LLONG_MAX_V) return TY_LLONG;
        return dec ? TY_NONE : TY_ULLONG;
      end
      SFX_U: begin
        if (v <= UINT_MAX_V) return TY_UINT;
        return (v <= ulmax) ? TY_ULONG : TY_ULLONG;
      end
      default: begin
        if (v <= INT_MAX_V) return TY_INT;
        if (!dec && v <= UINT_MAX_V) return TY_UINT;
        if (v <= lmax) return TY_LONG;
        if (!dec && v <= ulmax) return TY_ULONG;
        if (v <= LLONG_MAX_V) return TY_LLONG;
        return dec ? TY_NONE : TY_ULLONG;
      end
    endcase
  endfunction

  task automatic parse_char(input byte unsigned c, input logic last);
    logic [1:0]    idx;
    logic          consumed;
    int            d;
    logic [4:0]    base;
    logic [67:0]   prod;
    logic [64:0]   total;
    logic [2:0]    sfx, ty;
    parse_result_t r;
    idx = lex.char_index;
    if (lex.char_index < 2'd2) lex.char_index = lex.char_index + 2'd1;
    // after a bad octal digit the rest of the token is ignored
    consumed = lex.oct_err;
    if (!consumed && idx == 2'd0 && c == "0") begin
      lex.radix = RADIX_OCT;
      consumed = 1'b1;
    end
    // 0x only opens hex if something follows; a lone 0x is decimal 0 + 'x'
    if (!consumed && idx == 2'd1 && lex.radix == RADIX_OCT && (c == "x" || c == "X")) begin
      if (last) lex.radix = RADIX_DEC;
      else begin
        lex.radix = RADIX_HEX;
        consumed = 1'b1;
      end
    end
    if (!consumed && !lex.in_sfx) begin
      d = digit_in_radix(c, lex.radix);
      if (d >= 0) begin
        base = (lex.radix == RADIX_HEX) ? 5'd16 : ((lex.radix == RADIX_OCT) ? 5'd8 : 5'd10);
        prod = {4'd0, lex.acc} * base;
        total = {1'b0, prod[63:0]} + 65'(d);
        if (prod[67:64] != 4'd0 || total[64]) lex.ovf = 1'b1;
        lex.acc = total[63:0];
        consumed = 1'b1;
      end else if (lex.radix == RADIX_OCT && (c == "8" || c == "9")) begin
        lex.oct_err = 1'b1;
        consumed = 1'b1;
      end else begin
        lex.in_sfx = 1'b1;
      end
    end
    if (!consumed) advance_suffix(c);
    if (last) begin
      sfx = suffix_code_of(lex);
      r = '0;
      if (lex.oct_err) r.status = ST_BAD_OCT;
      else if (sfx == SFX_BAD) r.status = ST_BAD_SFX;
      else if (lex.ovf) r.status = ST_OVERFLOW;
      else begin
        r.status = ST_OK;
        r.literal_value = lex.acc;
        r.suffix_code = sfx;
        ty = c_type_for(lex.acc, lex.radix == RADIX_DEC, sfx, long_is_64_shadow);
        if (ty == TY_NONE) begin
          r.type_code = TY_ULLONG;
          r.forced_unsigned = 1'b1;
        end else begin
          r.type_code = ty;
        end
      end
      pending_results.push_back(r);
      lex = PARSE_RESET;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every word taken off the output is matched against the
  // oldest prediction. Sampled in the active region of the rising edge, so
  // the DUT's own updates at that edge are not yet visible.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_word = out_tdata[$bits(parse_result_t)-1:0];
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= SHOWN_MISMATCHES)
          $display("[%0d] unexpected result word %h", cycle_count, out_tdata);
      end else begin
        want_word = pending_results.pop_front();
        results_checked++;
        if (got_word.literal_value   !== want_word.literal_value ||
            got_word.type_code       !== want_word.type_code ||
            got_word.suffix_code     !== want_word.suffix_code ||
            got_word.status          !== want_word.status ||
            got_word.forced_unsigned !== want_word.forced_unsigned) begin
          mismatch_count++;
          if (mismatch_count <= SHOWN_MISMATCHES)
            $display({"[%0d] mismatch: want v=%h ty=%0d sfx=%0d st=%0d fu=%0d,",
                      " got v=%h ty=%0d sfx=%0d st=%0d fu=%0d"},
                     cycle_count, want_word.literal_value, want_word.type_code,
                     want_word.suffix_code, want_word.status, want_word.forced_unsigned,
                     got_word.literal_value, got_word.type_code, got_word.suffix_code,
                     got_word.status, got_word.forced_unsigned);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: per result word a random stall, or none in burst mode. A
  // requested hold-off keeps tready low for a long stretch so the skid
  // buffer fills and the input side backs up.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int gap;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (stall_hold > 0) begin
        out_tready <= 1'b0;
        repeat (stall_hold) @(negedge clk);
        stall_hold = 0;
      end
      gap = rx_burst ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid && stall_hold == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // One character word; valid stays high between back-to-back words.
  task automatic send_char(input byte unsigned c, input logic last);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    chars_sent++;
    parse_char(c, last);
  endtask

  task automatic send_token();
    for (int i = 0; i < token_buf.size(); i++)
      send_char(token_buf[i], i == token_buf.size() - 1);
    tokens_sent++;
  endtask

  // Drop valid, let every predicted word arrive, then a few spare cycles
  // in case a result-less word is still in the pipe.
  task automatic idle_until_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_long_width(input logic lp64);
    idle_until_drained();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= lp64;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    long_is_64_shadow = lp64;
  endtask

  task automatic add_digits(input int n, input string alphabet);
    for (int i = 0; i < n; i++)
      token_buf.push_back(alphabet[$urandom_range(0, alphabet.len() - 1)]);
  endtask

  task automatic add_suffix();
    suffix_shape_t shape;
    byte unsigned  u_ch, l_ch;
    int            n;
    u_ch  = $urandom_range(0, 1) ? "U" : "u";
    l_ch  = $urandom_range(0, 1) ? "L" : "l";
    shape = suffix_shape_t'($urandom_range(0, 9));
    case (shape)
      SG_U:   token_buf.push_back(u_ch);
      SG_L:   token_buf.push_back(l_ch);
      SG_UL:  begin token_buf.push_back(u_ch); token_buf.push_back(l_ch); end
      SG_LU:  begin token_buf.push_back(l_ch); token_buf.push_back(u_ch); end
      SG_ULL: begin
        token_buf.push_back(u_ch); token_buf.push_back(l_ch); token_buf.push_back(l_ch);
      end
      SG_LLU: begin
        token_buf.push_back(l_ch); token_buf.push_back(l_ch); token_buf.push_back(u_ch);
      end
      SG_LL:  begin token_buf.push_back(l_ch); token_buf.push_back(l_ch); end
      SG_MIXED_LL: begin
        // lL / Ll is not a valid ll
        token_buf.push_back(l_ch);
        token_buf.push_back(l_ch ^ 8'h20);
        if ($urandom_range(0, 1)) token_buf.push_back(u_ch);
      end
      SG_JUNK: begin
        n = $urandom_range(1, 3);
        repeat (n) begin
          if ($urandom_range(0, 1)) add_digits(1, "uUlLxzg.+");
          else token_buf.push_back(8'($urandom_range(0, 255)));
        end
      end
      default: ;
    endcase
  endtask

  // Mostly well-formed tokens with random content; some broken ones and noise.
  task automatic build_random_token();
    int pick, n;
    token_buf.delete();
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      // decimal; a share long enough to overflow
      n = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 10) : $urandom_range(15, 21);
      add_digits(1, "123456789");
      add_digits(n - 1, "0123456789");
      add_suffix();
    end else if (pick < 48) begin
      // octal, now and then with a stray 8 or 9
      token_buf.push_back("0");
      n = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 8) : $urandom_range(20, 23);
      add_digits(n, "01234567");
      if ($urandom_range(0, 9) == 0)
        token_buf.insert($urandom_range(1, token_buf.size()), $urandom_range(0, 1) ? "8" : "9");
      add_suffix();
    end else if (pick < 72) begin
      // hex; no digits gives either the empty-hex or the lone-0x case
      token_buf.push_back("0");
      token_buf.push_back($urandom_range(0, 1) ? "X" : "x");
      n = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 8) : $urandom_range(14, 18);
      add_digits(n, "0123456789abcdefABCDEF");
      add_suffix();
    end else if (pick < 80) begin
      // 19-digit decimal near the long long limit, half the time with LL added; often forced unsigned
      add_digits(1, "9");
      add_digits(18, "0123456789");
      add_suffix();
      if ($urandom_range(0, 1)) begin
        token_buf.push_back("L");
        token_buf.push_back("L");
      end
    end else if (pick < 90) begin
      // short decimal with a stray byte dropped in
      n = $urandom_range(1, 6);
      add_digits(n, "0123456789");
      token_buf.insert($urandom_range(0, token_buf.size()), 8'($urandom_range(0, 255)));
      add_suffix();
    end else begin
      n = $urandom_range(1, 5);
      repeat (n) token_buf.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Short hand-picked tokens: lone 0, lone 0x, empty hex, bad octal digit,
  // leading non-digit, mixed-case ll, the suffix orders, and the byte extremes.
  task automatic test_special_tokens();
    string specials[8];
    specials = '{"0", "0x", "0XL", "08u", "u", "7lL", "1Ul", "5llu"};
    foreach (specials[k]) begin
      token_buf.delete();
      for (int i = 0; i < specials[k].len(); i++) token_buf.push_back(specials[k][i]);
      send_token();
    end
    token_buf = '{8'h00};
    send_token();
    token_buf = '{8'hFF};
    send_token();
  endtask

  task automatic test_random_tokens(input int char_budget);
    int start;
    start = chars_sent;
    while (chars_sent - start < char_budget) begin
      // flip into and out of back-to-back stretches now and then
      if ($urandom_range(0, 19) == 0) tx_burst = !tx_burst;
      if ($urandom_range(0, 19) == 0) rx_burst = !rx_burst;
      build_random_token();
      send_token();
    end
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  task automatic test_long32_tokens();
    write_long_width(1'b0);
    test_random_tokens(700);
  endtask

  task automatic test_lp64_tokens();
    write_long_width(1'b1);
    test_random_tokens(700);
  endtask

  // Receiver holds off while the sender streams short tokens flat out.
  task automatic test_output_stall();
    idle_until_drained();
    tx_burst = 1'b1;
    stall_hold = 300;
    repeat (50) begin
      token_buf.delete();
      add_digits(1, "0123456789");
      add_suffix();
      send_token();
    end
    tx_burst = 1'b0;
  endtask

  task automatic test_long32_revisit();
    write_long_width(1'b0);
    test_random_tokens(400);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_special_tokens();    // long width still at its reset value (64)
    test_long32_tokens();
    test_lp64_tokens();
    test_output_stall();
    test_long32_revisit();

    idle_until_drained();
    repeat (8) @(posedge clk);

    $display("run: %0d tokens, %0d characters, %0d result words checked, %0d mismatches",
             tokens_sent, chars_sent, results_checked, mismatch_count);
    $display("long width 64/32/64/32, all radices and suffixes, one long output hold-off");
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
